@@ rtl/dec_pkg.sv @@
// Shared types, codes and constants of the debounced encoder counter.
`default_nettype none
package dec_pkg;

  // Request opcodes
  localparam logic [2:0] OP_EDGE  = 3'd0;
  localparam logic [2:0] OP_WRITE = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_SUB   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;
  localparam logic [2:0] OP_STEP  = 3'd5;

  // Direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // Multiplier step codes
  localparam logic [1:0] MSTEP_1   = 2'd0;
  localparam logic [1:0] MSTEP_10  = 2'd1;
  localparam logic [1:0] MSTEP_100 = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_DEBOUNCE = 2'd1;

  localparam int unsigned DB_W = 24;
  localparam logic [DB_W-1:0] ROT_DEBOUNCE_RESET = 24'd2500;
  localparam logic [DB_W-1:0] DIR_DEBOUNCE_RESET = 24'd100000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [63:0]        edge_time_us;
    logic               b_level;
    logic signed [31:0] write_value;
    logic [15:0]        delta;
  } dec_req_t;

  typedef struct packed {
    logic signed [31:0] count;
    logic [1:0]         direction;
    logic [6:0]         multiplier;
    logic               edge_counted;
  } dec_rsp_t;

  function automatic logic [6:0] mult_value(input logic [1:0] step);
    logic [6:0] v;
    case (step)
      MSTEP_10:  v = 7'd10;
      MSTEP_100: v = 7'd100;
      default:   v = 7'd1;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dec_update.sv @@
// Next-state and result logic for one request of the encoder counter.
`default_nettype none
module dec_update #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 64
) (
  input  dec_pkg::dec_req_t        req,
  input  logic [COUNT_WIDTH-1:0]   tick_count,
  input  logic [1:0]               last_dir,
  input  logic [TIME_WIDTH-1:0]    last_time,
  input  logic [1:0]               mult_step,
  input  logic [dec_pkg::DB_W-1:0] rot_db,
  input  logic [dec_pkg::DB_W-1:0] dir_db,
  output logic [COUNT_WIDTH-1:0]   tick_count_next,
  output logic [1:0]               last_dir_next,
  output logic [TIME_WIDTH-1:0]    last_time_next,
  output logic [1:0]               mult_step_next,
  output dec_pkg::dec_rsp_t        rsp
);
  import dec_pkg::*;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  rot_ok;
  logic                  dir_ok;
  logic [1:0]            want_dir;
  logic                  counted;
  logic [63:0]           wv_ext;
  logic [63:0]           delta_ext;
  logic [63:0]           cnt_ext;

  assign now_t     = req.edge_time_us[TIME_WIDTH-1:0];
  assign elapsed   = now_t - last_time;
  assign rot_ok    = elapsed > TIME_WIDTH'(rot_db);
  assign want_dir  = req.b_level ? DIR_REV : DIR_FWD;
  assign dir_ok    = (last_dir == want_dir) || (elapsed > TIME_WIDTH'(dir_db));
  assign wv_ext    = {{32{req.write_value[31]}}, req.write_value};
  assign delta_ext = 64'(req.delta);

  always_comb begin
    tick_count_next = tick_count;
    last_dir_next   = last_dir;
    last_time_next  = last_time;
    mult_step_next  = mult_step;
    counted         = 1'b0;
    case (req.opcode)
      OP_EDGE: begin
        if (rot_ok) begin
          last_time_next = now_t;
          if (dir_ok) begin
            last_dir_next   = want_dir;
            counted         = 1'b1;
            tick_count_next = req.b_level ? tick_count - COUNT_WIDTH'(1'b1)
                                          : tick_count + COUNT_WIDTH'(1'b1);
          end
        end
      end
      OP_WRITE: tick_count_next = wv_ext[COUNT_WIDTH-1:0];
      OP_ADD:   tick_count_next = tick_count + delta_ext[COUNT_WIDTH-1:0];
      OP_SUB:   tick_count_next = tick_count - delta_ext[COUNT_WIDTH-1:0];
      OP_CLEAR: tick_count_next = '0;
      OP_STEP:  mult_step_next = (mult_step >= MSTEP_100) ? MSTEP_1 : mult_step + 2'd1;
      default: ;
    endcase
  end

  // Count leaves zero-extended from the counter width, then cut to 32 bits.
  assign cnt_ext = 64'(tick_count_next);

  always_comb begin
    rsp.count        = cnt_ext[31:0];
    rsp.direction    = last_dir_next;
    rsp.multiplier   = mult_value(mult_step_next);
    rsp.edge_counted = counted;
  end

endmodule
`default_nettype wire

@@ rtl/debounced_encoder_counter.sv @@
// Top level of the debounced rotary encoder tick counter.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request: an encoder
//   edge (timestamp and B level) or a count command (write, add, subtract,
//   clear, step multiplier). Every request yields exactly one response on
//   the rsp channel (rsp_valid / rsp_stall / rsp) with the count, last
//   direction, multiplier and an edge-counted flag after that request.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   rotation and direction debounce registers; cfg_ready is always high.
//   Write them only while no request is in flight.
// Timing:
//   A request is registered in the request register on acceptance,
//   evaluated against the state, and its response registered in the
//   response register when the stage advances.
//   One request per cycle is sustained while rsp_stall is low; the state
//   update is a single subtract-and-compare plus a counter add between the
//   request register and the response register.
// Reset (rst, synchronous): count, direction, last-edge time and multiplier
//   clear; debounce registers return to 2500 us and 100000 us.
// Stall: while rsp_stall holds a response, the request register can still
//   take one more request; after that req_stall rises until the response
//   is taken.
`default_nettype none
module debounced_encoder_counter #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  dec_pkg::dec_req_t                 req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output dec_pkg::dec_rsp_t                 rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dec_pkg::DB_W-1:0]          cfg_data
);
  import dec_pkg::*;

  // Debounce settings
  logic [DB_W-1:0] rot_db;
  logic [DB_W-1:0] dir_db;

  // Block state
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [1:0]             last_dir;
  logic [TIME_WIDTH-1:0]  last_time;
  logic [1:0]             mult_step;

  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic [1:0]             last_dir_next;
  logic [TIME_WIDTH-1:0]  last_time_next;
  logic [1:0]             mult_step_next;

  // Request register
  dec_req_t stg_req;
  logic     stg_valid;

  dec_rsp_t rsp_next;
  logic     req_take;
  logic     advance;

  assign cfg_ready = 1'b1;

  // The stage moves into the response register when that is empty or
  // being drained this cycle.
  assign advance   = stg_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = stg_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_db <= ROT_DEBOUNCE_RESET;
      dir_db <= DIR_DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROT_DEBOUNCE) begin
        rot_db <= cfg_data;
      end else if (cfg_index == REG_DIR_DEBOUNCE) begin
        dir_db <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req_take) begin
      stg_valid <= 1'b1;
    end else if (advance) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      stg_req <= req;
    end
  end

  dec_update #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_update (
    .req            (stg_req),
    .tick_count     (tick_count),
    .last_dir       (last_dir),
    .last_time      (last_time),
    .mult_step      (mult_step),
    .rot_db         (rot_db),
    .dir_db         (dir_db),
    .tick_count_next(tick_count_next),
    .last_dir_next  (last_dir_next),
    .last_time_next (last_time_next),
    .mult_step_next (mult_step_next),
    .rsp            (rsp_next)
  );

  // State commits together with the response, so the next request in the
  // stage is evaluated against the committed state.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      last_dir   <= DIR_NONE;
      last_time  <= '0;
      mult_step  <= MSTEP_1;
    end else if (advance) begin
      tick_count <= tick_count_next;
      last_dir   <= last_dir_next;
      last_time  <= last_time_next;
      mult_step  <= mult_step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // Multiplier step never reaches the unused code.
  a_mult_step_range: assert property (@(posedge clk) disable iff (rst)
    mult_step != 2'd3)
    else $error("multiplier step out of range");

  // A counted edge always leaves a direction behind.
  a_counted_dir: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.edge_counted) |-> (rsp.direction != DIR_NONE))
    else $error("counted edge without direction");

  // Response direction matches the committed direction state.
  a_rsp_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (rsp.direction == last_dir))
    else $error("response direction out of step with state");

  // Request stall only while a request sits in the stage.
  a_stall_stage: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (stg_valid && rsp_valid))
    else $error("request stalled with free stage");

endmodule
`default_nettype wire

@@ dv/encoder_count_checker.sv @@
// Checker for the debounced encoder counter: predicts every response and compares it.
module encoder_count_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  dec_pkg::dec_req_t             req,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  dec_pkg::dec_rsp_t             rsp,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [dec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dec_pkg::DB_W-1:0]      cfg_data,
  output int                            mismatches,
  output int                            outstanding,
  output int                            checked,
  output int                            edges_counted
);
  import dec_pkg::*;

  // shadow of the counter state and debounce registers
  logic [31:0]     cnt_q     = '0;
  logic [1:0]      dir_q     = DIR_NONE;
  logic [63:0]     edge_t_q  = '0;
  logic [1:0]      mstep_q   = MSTEP_1;
  logic [DB_W-1:0] rot_db_q  = ROT_DEBOUNCE_RESET;
  logic [DB_W-1:0] dir_db_q  = DIR_DEBOUNCE_RESET;

  dec_rsp_t expected_rsp_q[$];
  int n_bad     = 0;
  int n_checked = 0;
  int n_counted = 0;

  function automatic dec_rsp_t advance_counter(input dec_req_t r);
    dec_rsp_t   o;
    logic [63:0] elapsed;
    logic [1:0]  want;
    o.edge_counted = 1'b0;
    case (r.opcode)
      OP_EDGE: begin
        elapsed = r.edge_time_us - edge_t_q;  // modulo 2^64
        if (elapsed > {40'd0, rot_db_q}) begin
          want = r.b_level ? DIR_REV : DIR_FWD;
          if (dir_q == want || elapsed > {40'd0, dir_db_q}) begin
            dir_q = want;
            cnt_q = r.b_level ? cnt_q - 32'd1 : cnt_q + 32'd1;
            o.edge_counted = 1'b1;
          end
          edge_t_q = r.edge_time_us;
        end
      end
      OP_WRITE: cnt_q = r.write_value;
      OP_ADD:   cnt_q = cnt_q + {16'd0, r.delta};
      OP_SUB:   cnt_q = cnt_q - {16'd0, r.delta};
      OP_CLEAR: cnt_q = '0;
      OP_STEP:  mstep_q = (mstep_q >= MSTEP_100) ? MSTEP_1 : mstep_q + 2'd1;
      default: ;
    endcase
    o.count     = cnt_q;
    o.direction = dir_q;
    case (mstep_q)
      MSTEP_10:  o.multiplier = 7'd10;
      MSTEP_100: o.multiplier = 7'd100;
      default:   o.multiplier = 7'd1;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    dec_rsp_t exp_r;
    logic     bad;
    if (rst) begin
      cnt_q    = '0;
      dir_q    = DIR_NONE;
      edge_t_q = '0;
      mstep_q  = MSTEP_1;
      rot_db_q = ROT_DEBOUNCE_RESET;
      dir_db_q = DIR_DEBOUNCE_RESET;
      expected_rsp_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROT_DEBOUNCE)
          rot_db_q = cfg_data;
        else if (cfg_index == REG_DIR_DEBOUNCE)
          dir_db_q = cfg_data;
      end
      if (req_valid && !req_stall)
        expected_rsp_q.push_back(advance_counter(req));
      if (rsp_valid && !rsp_stall) begin
        n_checked++;
        if (expected_rsp_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("response with nothing expected: ",
                     "count %0d dir %0d mult %0d counted %0b",
                     rsp.count, rsp.direction, rsp.multiplier, rsp.edge_counted);
        end else begin
          exp_r = expected_rsp_q.pop_front();
          if (exp_r.edge_counted)
            n_counted++;
          bad = (rsp.count !== exp_r.count) || (rsp.direction !== exp_r.direction) ||
                (rsp.multiplier !== exp_r.multiplier) ||
                (rsp.edge_counted !== exp_r.edge_counted);
          if (bad) begin
            n_bad++;
            if (n_bad <= 10)
              $display("response %0d wrong: exp count %0d dir %0d mult %0d counted %0b,",
                       n_checked, exp_r.count, exp_r.direction, exp_r.multiplier,
                       exp_r.edge_counted, " got %0d %0d %0d %0b",
                       rsp.count, rsp.direction, rsp.multiplier, rsp.edge_counted);
          end
        end
      end
    end
    mismatches    <= n_bad;
    outstanding   <= expected_rsp_q.size();
    checked       <= n_checked;
    edges_counted <= n_counted;
  end

endmodule

@@ dv/tb_debounced_encoder_counter.sv @@
// Testbench top for the debounced encoder counter: stimulus, handshakes and verdict.
module tb_debounced_encoder_counter;
  import dec_pkg::*;

  // no acceptance on any channel for this many cycles means the block hung
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int N_PHASES         = 8;

  // opcodes the block ignores, register indexes it has no register for
  localparam logic [2:0]           OP_SPARE_6  = 3'd6;
  localparam logic [2:0]           OP_SPARE_7  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [DB_W-1:0]      DB_MAX      = '1;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} stall_mode_t;

  logic clk;
  logic rst = 1'b1;

  logic                 req_valid = 1'b0;
  logic                 req_stall;
  dec_req_t             req       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  dec_rsp_t             rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DB_W-1:0]      cfg_data  = '0;

  int mismatches;
  int outstanding;
  int checked;
  int edges_counted;

  // stimulus-side view of the debounce settings, used to place edge times
  logic [DB_W-1:0] cur_rot_db = ROT_DEBOUNCE_RESET;
  logic [DB_W-1:0] cur_dir_db = DIR_DEBOUNCE_RESET;
  logic [63:0]     tb_now     = '0;
  logic            b_pref     = 1'b0;
  int              n_sent     = 0;

  debounced_encoder_counter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  encoder_count_checker count_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .checked       (checked),
    .edges_counted (edges_counted)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Response side stalls in stretches of its own: none, light, heavy, or
  // solid. Independent of the request bursts so the gaps land on every
  // phase of the pipeline.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == STALL_SOLID) ? int'($urandom_range(1, 8))
                                               : int'($urandom_range(4, 40));
    end
    stall_left--;
    case (stall_mode)
      STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
      STALL_SOLID: rsp_stall <= 1'b1;
      default:     rsp_stall <= 1'b0;
    endcase
  end

  // Watchdog: any accepted request, response or register write is progress.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d responses still due",
               WATCHDOG_LIMIT, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic dec_req_t make_req(input logic [2:0] op, input logic [63:0] t,
                                        input logic b, input logic [31:0] wv,
                                        input logic [15:0] d);
    dec_req_t r;
    r.opcode       = op;
    r.edge_time_us = t;
    r.b_level      = b;
    r.write_value  = wv;
    r.delta        = d;
    return r;
  endfunction

  // Present one request and hold it until taken. Valid is only raised when
  // it is low so back-to-back requests never see a second assignment.
  task automatic send_req(input dec_req_t r);
    req <= r;
    if (!req_valid)
      req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    n_sent++;
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [DB_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    if (!cfg_valid)
      cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drop valid, let every due response come back, then leave slack for the
  // two-stage pipeline before anything else happens.
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    dec_req_t        r;
    logic [63:0]     gap;
    logic [DB_W-1:0] rot_v, dir_v;
    int              phase, k, sel, burst_left;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, reset debounce values (2500 / 100000 us) ----
    // edge at time zero: nothing elapsed since the reset edge time
    send_req(make_req(OP_EDGE, 64'd0, 1'b0, 32'd0, 16'd0));
    // exactly at the rotation debounce: not strictly greater, ignored
    send_req(make_req(OP_EDGE, 64'd2500, 1'b0, 32'd0, 16'd0));
    // passes rotation, but first direction comes too soon: rejected,
    // last-edge time still moves
    send_req(make_req(OP_EDGE, 64'd2501, 1'b0, 32'd0, 16'd0));
    tb_now = 64'd2501 + 64'd100001;
    send_req(make_req(OP_EDGE, tb_now, 1'b0, 32'd0, 16'd0));
    tb_now += 64'd3000;
    send_req(make_req(OP_EDGE, tb_now, 1'b0, 32'd0, 16'd0));
    // quick reversal: rejected
    tb_now += 64'd3000;
    send_req(make_req(OP_EDGE, tb_now, 1'b1, 32'd0, 16'd0));
    // reversal exactly at the direction debounce: still rejected
    tb_now += 64'd100000;
    send_req(make_req(OP_EDGE, tb_now, 1'b1, 32'd0, 16'd0));
    tb_now += 64'd100001;
    send_req(make_req(OP_EDGE, tb_now, 1'b1, 32'd0, 16'd0));
    // count overflow through an edge
    send_req(make_req(OP_WRITE, 64'd0, 1'b0, 32'h7FFF_FFFF, 16'd0));
    tb_now += 64'd100001;
    send_req(make_req(OP_EDGE, tb_now, 1'b0, 32'd0, 16'd0));
    // overflow through the arithmetic commands
    send_req(make_req(OP_SUB, 64'd0, 1'b0, 32'd0, 16'd1));
    send_req(make_req(OP_ADD, 64'd0, 1'b0, 32'd0, 16'hFFFF));
    send_req(make_req(OP_WRITE, 64'd0, 1'b0, 32'h8000_0000, 16'd0));
    send_req(make_req(OP_SUB, 64'd0, 1'b0, 32'd0, 16'hFFFF));
    send_req(make_req(OP_CLEAR, 64'd0, 1'b0, 32'd0, 16'd0));
    // multiplier 1 -> 10 -> 100 -> 1
    repeat (3) send_req(make_req(OP_STEP, 64'd0, 1'b0, 32'd0, 16'd0));
    // opcodes with no meaning leave the state alone
    send_req(make_req(OP_SPARE_6, '1, 1'b1, '1, '1));
    send_req(make_req(OP_SPARE_7, '1, 1'b1, '1, '1));
    // timestamp wrap: just below 2^64, then across it
    tb_now = 64'hFFFF_FFFF_FFFF_FF00;
    send_req(make_req(OP_EDGE, tb_now, 1'b0, 32'd0, 16'd0));
    tb_now += 64'd3000;
    send_req(make_req(OP_EDGE, tb_now, 1'b0, 32'd0, 16'd0));
    wait_idle();

    // ---- random part, one debounce setting per phase ----
    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin rot_v = ROT_DEBOUNCE_RESET; dir_v = DIR_DEBOUNCE_RESET; end
        1: begin rot_v = '0;                 dir_v = '0;                 end
        2: begin rot_v = DB_MAX;             dir_v = DB_MAX;             end
        3: begin rot_v = '0;                 dir_v = DB_MAX;             end
        4: begin rot_v = DB_MAX;             dir_v = '0;                 end
        5: begin
          rot_v = DB_W'($urandom_range(0, 5000));
          dir_v = DB_W'($urandom_range(0, 200000));
        end
        6: begin rot_v = DB_W'($urandom);    dir_v = DB_W'($urandom);    end
        default: begin rot_v = 24'd10;       dir_v = 24'd1000;           end
      endcase
      cfg_put(REG_ROT_DEBOUNCE, rot_v);
      cfg_put(REG_DIR_DEBOUNCE, dir_v);
      // writes to indexes with no register behind them must not land
      if (phase == 3 || phase == 6) begin
        cfg_put(REG_SPARE_2, DB_W'($urandom));
        cfg_put(REG_SPARE_3, DB_W'($urandom));
      end
      cfg_valid <= 1'b0;
      @(posedge clk);
      cur_rot_db = rot_v;
      cur_dir_db = dir_v;

      burst_left = 0;
      for (k = 0; k < RANDOM_PER_PHASE; k++) begin
        // bursts of requests with random gaps; sometimes no gap at all
        if (burst_left == 0) begin
          if (req_valid && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
          end
          burst_left = int'($urandom_range(1, 30));
        end
        burst_left--;

        // background content everywhere so every field bit toggles
        r.edge_time_us = {$urandom, $urandom};
        r.b_level      = 1'($urandom_range(0, 1));
        r.write_value  = $urandom;
        r.delta        = 16'($urandom);
        sel = int'($urandom_range(0, 99));
        if (sel < 70) begin
          // edges mostly well spaced, mostly same direction; some bounce,
          // some land on the debounce boundaries, some jump far (and wrap)
          r.opcode = OP_EDGE;
          case ($urandom_range(0, 9))
            0:          gap = 64'($urandom_range(0, cur_rot_db));
            1:          gap = 64'(cur_rot_db);
            2:          gap = 64'(cur_rot_db) + 64'd1;
            3, 4, 5, 6: gap = 64'(cur_rot_db) + 64'd1 + 64'($urandom_range(0, 2000));
            7:          gap = 64'(cur_dir_db) + 64'($urandom_range(0, 1));
            8:          gap = 64'(cur_dir_db) + 64'd1 + 64'($urandom_range(0, 100000));
            default:    gap = {$urandom, $urandom};
          endcase
          tb_now = tb_now + gap;
          r.edge_time_us = tb_now;
          if ($urandom_range(0, 6) == 0)
            b_pref = ~b_pref;
          r.b_level = b_pref;
        end else if (sel < 76) begin
          r.opcode = OP_WRITE;
          case ($urandom_range(0, 3))
            0:       r.write_value = 32'h7FFF_FFFF;
            1:       r.write_value = 32'h8000_0000;
            default: ;
          endcase
        end else if (sel < 82) begin
          r.opcode = OP_ADD;
        end else if (sel < 88) begin
          r.opcode = OP_SUB;
        end else if (sel < 92) begin
          r.opcode = OP_CLEAR;
        end else if (sel < 97) begin
          r.opcode = OP_STEP;
        end else begin
          r.opcode = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        send_req(r);
      end
      wait_idle();
    end

    $display("Sent %0d requests over %0d debounce settings plus the reset values.",
             n_sent, N_PHASES);
    $display("Checked %0d responses, %0d edges counted, %0d mismatches.",
             checked, edges_counted, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
